// File: rtl/nmea_sentence_framer_macros.svh
// assertion macros for the nmea sentence framer
// each expects signals named clock and reset in the using module
`ifndef NMEA_SENTENCE_FRAMER_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock outside reset
`define NSF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define NSF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define NSF_ASSERT_ALWAYS(label, cond, msg)
`define NSF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/nsf_pkg.sv
package nsf_pkg;

   localparam int unsigned MAX_LEN = 83;
   localparam int unsigned LEN_W   = 7;

   localparam logic [7:0] CH_START = 8'h24;
   localparam logic [7:0] CH_END   = 8'h0A;
   localparam logic [7:0] CH_STAR  = 8'h2A;

   // hex decoder result: bit 4 set means not a hex digit
   localparam logic [4:0] HEX_BAD = 5'd16;

   localparam logic [LEN_W-1:0] MAX_LEN_C   = LEN_W'(MAX_LEN);
   localparam logic [LEN_W-1:0] SHORT_LIMIT = LEN_W'(3);

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_MISMATCH = 3'd1,
      STAT_NO_SUM   = 3'd2,
      STAT_SHORT    = 3'd3,
      STAT_OVERFLOW = 3'd4
   } frame_status_type;

   typedef enum logic {
      KIND_BODY = 1'b0,
      KIND_END  = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type    item_kind;
      logic [7:0]       body_byte;
      frame_status_type frame_status;
      logic [7:0]       computed_sum;
      logic [7:0]       received_sum;
      logic [LEN_W-1:0] frame_length;
   } rsp_item_type;

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = HEX_BAD;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 5'(c - 8'h61 + 8'd10);
      end
      return v;
   endfunction

endpackage

// File: rtl/nsf_req_if.sv
interface nsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/nsf_rsp_if.sv
interface nsf_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [7:0] body_byte;
   logic [2:0] frame_status;
   logic [7:0] computed_sum;
   logic [7:0] received_sum;
   logic [6:0] frame_length;

   modport source (output valid, output item_kind, output body_byte, output frame_status,
                   output computed_sum, output received_sum, output frame_length,
                   input ready);
   modport sink (input valid, input item_kind, input body_byte, input frame_status,
                 input computed_sum, input received_sum, input frame_length,
                 output ready);
endinterface

// File: rtl/nsf_in_stage.sv
module nsf_in_stage import nsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_byte,
   output logic       req_ready,
   input  logic       take,
   output logic       in_vld,
   output logic [7:0] in_byte
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       accept;

   assign req_ready = !in_vld_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (accept) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_byte;
      end else if (take) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      in_byte_ff <= in_byte_in;
   end

   assign in_vld  = in_vld_ff;
   assign in_byte = in_byte_ff;

endmodule

// File: rtl/nsf_frame_core.sv
`include "nmea_sentence_framer_macros.svh"

module nsf_frame_core import nsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   in_byte,
   output logic         res_vld,
   output rsp_item_type res_item
);

   logic             in_frame_ff, in_frame_in;
   logic [LEN_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]       running_xor_ff, running_xor_in;
   logic             star_seen_ff, star_seen_in;
   logic [2:0]       after_star_ff, after_star_in;
   logic [7:0]       digit_value_ff, digit_value_in;
   logic             digit_bad_ff, digit_bad_in;

   logic [LEN_W-1:0] count_next;
   logic [4:0]       hex_v;
   logic [3:0]       nibble;
   logic             sum_ok;

   assign count_next = byte_count_ff + LEN_W'(1);
   assign hex_v      = hex_value(in_byte);
   assign nibble     = hex_v[4] ? 4'd0 : hex_v[3:0];
   assign sum_ok     = !digit_bad_ff && (digit_value_ff == running_xor_ff);

   always_comb begin
      in_frame_in    = in_frame_ff;
      byte_count_in  = byte_count_ff;
      running_xor_in = running_xor_ff;
      star_seen_in   = star_seen_ff;
      after_star_in  = after_star_ff;
      digit_value_in = digit_value_ff;
      digit_bad_in   = digit_bad_ff;
      res_vld        = 1'b0;
      res_item       = '0;

      if (step) begin
         if (!in_frame_ff) begin
            if (in_byte == CH_START) begin
               in_frame_in    = 1'b1;
               byte_count_in  = LEN_W'(1);
               running_xor_in = '0;
               star_seen_in   = 1'b0;
               after_star_in  = '0;
               digit_value_in = '0;
               digit_bad_in   = 1'b0;
            end
         end else if (count_next < MAX_LEN_C && in_byte != CH_END) begin
            byte_count_in = count_next;
            if (!star_seen_ff) begin
               if (in_byte == CH_STAR) begin
                  star_seen_in  = 1'b1;
                  after_star_in = '0;
               end else begin
                  running_xor_in     = running_xor_ff ^ in_byte;
                  res_vld            = 1'b1;
                  res_item.item_kind = KIND_BODY;
                  res_item.body_byte = in_byte;
               end
            end else begin
               if (after_star_ff < 3'd2) begin
                  if (hex_v[4]) begin
                     digit_bad_in = 1'b1;
                  end
                  if (after_star_ff == 3'd0) begin
                     digit_value_in = {nibble, 4'd0};
                  end else begin
                     digit_value_in = digit_value_ff | {4'd0, nibble};
                  end
               end
               if (after_star_ff != 3'd7) begin
                  after_star_in = after_star_ff + 3'd1;
               end
            end
         end else begin
            res_vld               = 1'b1;
            res_item.item_kind    = KIND_END;
            res_item.computed_sum = running_xor_ff;
            res_item.frame_length = count_next;
            if (count_next >= MAX_LEN_C) begin
               res_item.frame_status = STAT_OVERFLOW;
            end else if (count_next <= SHORT_LIMIT) begin
               res_item.frame_status = STAT_SHORT;
            end else if (star_seen_ff && after_star_ff == 3'd3) begin
               res_item.frame_status = sum_ok ? STAT_OK : STAT_MISMATCH;
               res_item.received_sum = digit_value_ff;
            end else begin
               res_item.frame_status = STAT_NO_SUM;
            end
            in_frame_in    = 1'b0;
            byte_count_in  = '0;
            running_xor_in = '0;
            star_seen_in   = 1'b0;
            after_star_in  = '0;
            digit_value_in = '0;
            digit_bad_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         byte_count_ff  <= '0;
         running_xor_ff <= '0;
         star_seen_ff   <= 1'b0;
         after_star_ff  <= '0;
         digit_value_ff <= '0;
         digit_bad_ff   <= 1'b0;
      end else begin
         in_frame_ff    <= in_frame_in;
         byte_count_ff  <= byte_count_in;
         running_xor_ff <= running_xor_in;
         star_seen_ff   <= star_seen_in;
         after_star_ff  <= after_star_in;
         digit_value_ff <= digit_value_in;
         digit_bad_ff   <= digit_bad_in;
      end
   end

   `NSF_ASSERT_ALWAYS(a_star_in_frame, star_seen_ff |-> in_frame_ff, "star seen while hunting")
   `NSF_ASSERT_ALWAYS(a_count_range, in_frame_ff |-> (byte_count_ff != '0 && byte_count_ff < MAX_LEN_C), "byte count out of range")
   `NSF_ASSERT_ALWAYS(a_hunt_clear, !in_frame_ff |-> (byte_count_ff == '0 && running_xor_ff == '0), "frame state not cleared while hunting")
   `NSF_ASSERT_ALWAYS(a_digits_after_star, !star_seen_ff |-> (after_star_ff == '0 && !digit_bad_ff), "checksum digits without star")
   `NSF_ASSERT_NEXT(a_end_clears, res_vld && res_item.item_kind == KIND_END, !in_frame_ff, "frame not closed after end word")

endmodule

// File: rtl/nsf_out_stage.sv
module nsf_out_stage import nsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   input  logic         rsp_ready,
   output logic         can_take,
   output logic         out_vld,
   output rsp_item_type out_item
);

   logic         out_vld_ff, out_vld_in;
   rsp_item_type out_item_ff, out_item_in;

   assign can_take = !out_vld_ff || rsp_ready;

   always_comb begin
      out_item_in = out_item_ff;
      if (load) begin
         out_vld_in  = 1'b1;
         out_item_in = load_item;
      end else begin
         out_vld_in = out_vld_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      out_item_ff <= out_item_in;
   end

   assign out_vld  = out_vld_ff;
   assign out_item = out_item_ff;

endmodule

// File: rtl/nmea_sentence_framer.sv
// nmea 0183 sentence framer: takes one received byte per word on req_chan and hunts
// for '$', then counts the sentence through '\n'. every body byte before the first
// '*' comes out at once on rsp_chan as a provisional body word (item_kind 0) and is
// xored into the running checksum; at '\n', or when the count reaches MAX_LEN (83),
// one end word (item_kind 1) carries the status (ok, checksum mismatch, no checksum,
// too short, overflow), the computed and received sums and the sentence length. a
// checksum counts only as '*', two hex digits and one trailing byte (normally cr,
// dropped); a non-hex digit reads as a mismatch. the consumer keeps or drops the
// provisional bytes by the status. throughput is one byte per clock unless rsp_chan
// stalls: the whole per-byte update is one step of the frame state registers. an
// accepted byte passes through the input register and then the result register;
// bytes that cause no result (hunting, '*', checksum digits) leave nothing.
module nmea_sentence_framer import nsf_pkg::*; (
   input  logic clock,
   input  logic reset,
   nsf_req_if.sink   req_chan,
   nsf_rsp_if.source rsp_chan
);

   // input register
   logic         in_vld;
   logic [7:0]   in_byte;
   logic         advance;

   // frame state update
   logic         res_vld;
   rsp_item_type res_item;

   // result register
   logic         out_can_take;
   logic         out_vld;
   rsp_item_type out_item;

   // a byte moves on when the result register is free or being drained
   assign advance = in_vld && out_can_take;

   nsf_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_byte  (req_chan.rx_byte),
      .req_ready (req_chan.ready),
      .take      (advance),
      .in_vld    (in_vld),
      .in_byte   (in_byte)
   );

   nsf_frame_core u_frame_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .in_byte  (in_byte),
      .res_vld  (res_vld),
      .res_item (res_item)
   );

   // only bytes that produce a word load the result register
   nsf_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (res_vld),
      .load_item (res_item),
      .rsp_ready (rsp_chan.ready),
      .can_take  (out_can_take),
      .out_vld   (out_vld),
      .out_item  (out_item)
   );

   // result word onto the channel
   assign rsp_chan.valid        = out_vld;
   assign rsp_chan.item_kind    = out_item.item_kind;
   assign rsp_chan.body_byte    = out_item.body_byte;
   assign rsp_chan.frame_status = out_item.frame_status;
   assign rsp_chan.computed_sum = out_item.computed_sum;
   assign rsp_chan.received_sum = out_item.received_sum;
   assign rsp_chan.frame_length = out_item.frame_length;

endmodule
